@@ hw/rtl/b64dec_pkg.sv @@
// ----------------------------------------------------------------------------
// b64dec_pkg
// shared types and constants of the checked base64 decoder
// ----------------------------------------------------------------------------
package b64dec_pkg;

    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned SEXTET_W     = 6;
    localparam int unsigned ACC_W        = 18;
    localparam int unsigned WORD_W       = 24;
    localparam int unsigned MAX_GROUPS_W = 17;
    localparam int unsigned STATUS_W     = 3;

    localparam logic [MAX_GROUPS_W-1:0] MAX_GROUPS_RESET = 17'd87382;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

    // end-of-message status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAD_ORDER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

    // place of a character within its group
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    // alphabet lookup, invalid characters (pad included) give value 0
    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = SEXTET_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/base64_decoder_checked_top.sv @@
// ----------------------------------------------------------------------------
// base64_decoder_checked_top
// streaming base64 decoder with per-message error status
//
//  channel  | direction | tdata                          | tuser / tlast
//  ---------+-----------+--------------------------------+-----------------------------
//  s_       | in        | [7:0] char_code                | tlast: final_char
//  m_       | out       | [7:0] data_byte, [10:8] status | tuser [0] has_byte,
//           |           | [15:11] zero                   | [1] message_end; tlast: last_of_run
//  cfg_wr_  | in        | [16:0] max_groups              | write on cfg_wr_en
//
// one character is taken per cycle into the input register while s_tready is high; the decode
// step runs between that register and the result bundle register
// a character that makes more than one result holds the result bundle until the last of
// them is sent, and the next character waits in the input register until then, since
// the single result port sends the bytes and the end result one at a time
// synchronous active-low reset clears decoder state and sets max_groups to 87382
// m_tready low stalls the bundle; the input register still fills once
// ----------------------------------------------------------------------------
module base64_decoder_checked_top
    import b64dec_pkg::*;
#(
    parameter int unsigned GROUP_COUNT_BITS = 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [MAX_GROUPS_W-1:0] cfg_wr_data,   // max_groups

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,       // [7:0] char_code
    input  logic                    s_tlast,       // final_char

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,       // [7:0] data_byte, [10:8] status, [15:11] 0
    output logic [1:0]              m_tuser,       // [0] has_byte, [1] message_end
    output logic                    m_tlast        // last_of_run
);

    localparam int unsigned CMP_W =
        (GROUP_COUNT_BITS > MAX_GROUPS_W) ? GROUP_COUNT_BITS : MAX_GROUPS_W;

    // configuration
    logic [MAX_GROUPS_W-1:0]     max_groups_reg;

    // input register
    logic                        in_valid_reg;
    logic [CHAR_W-1:0]           in_char_reg;
    logic                        in_last_reg;

    // decoder state
    logic [1:0]                  pos_reg, pos_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic                        third_pad_reg, third_pad_next;
    logic [GROUP_COUNT_BITS-1:0] gc_reg, gc_next;
    logic [STATUS_W-1:0]         err_reg, err_next;
    logic                        too_long_reg, too_long_next;

    // result bundle: up to three bytes and an end result
    logic                        bnd_valid_reg;
    logic [1:0]                  bnd_idx_reg;
    logic [1:0]                  bnd_last_idx_reg, bnd_last_idx_next;
    logic [1:0]                  bnd_nbytes_reg, bnd_nbytes_next;
    logic [WORD_W-1:0]           bnd_word_reg, bnd_word_next;
    logic [STATUS_W-1:0]         bnd_status_reg, bnd_status_next;
    logic                        bnd_has_next;

    logic                        m_xfer;
    logic                        bnd_done;
    logic                        load;

    sextet_t                     sx;
    logic                        is_pad;
    logic [SEXTET_W-1:0]         sx_val;
    logic [WORD_W-1:0]           word;
    logic [2:0]                  n_res;
    logic                        emit;
    logic [7:0]                  out_byte;
    logic                        out_is_byte;

    // ---------------------------------------------------------------- handshake
    assign m_xfer   = m_tvalid && m_tready;
    assign bnd_done = m_xfer && (bnd_idx_reg == bnd_last_idx_reg);
    // the bundle takes a decoded character when empty or on its last transfer
    assign load     = in_valid_reg && (!bnd_valid_reg || bnd_done);
    assign s_tready = !in_valid_reg || load;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_groups_reg <= MAX_GROUPS_RESET;
        end else if (cfg_wr_en) begin
            max_groups_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // ---------------------------------------------------------------- decode step
    always_comb begin
        sx              = sextet_of(in_char_reg);
        is_pad          = (in_char_reg == PAD_CHAR);
        sx_val          = sx.value;

        pos_next        = pos_reg;
        acc_next        = acc_reg;
        third_pad_next  = third_pad_reg;
        gc_next         = gc_reg;
        err_next        = err_reg;
        too_long_next   = too_long_reg;
        word            = {acc_reg, sx_val};
        emit            = 1'b0;
        bnd_nbytes_next = 2'd0;
        bnd_has_next    = 1'b0;
        bnd_status_next = ST_OK;

        if (pos_reg < POS_THIRD) begin
            // first and second place: no padding allowed here
            if (err_reg == ST_OK) begin
                if (is_pad) begin
                    err_next = ST_PAD_ORDER;
                end else if (!sx.valid) begin
                    err_next = ST_BAD_CHAR;
                end
            end
            acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], sx_val};
            pos_next = pos_reg + 2'd1;
        end else if (pos_reg == POS_THIRD) begin
            third_pad_next = is_pad;
            if (err_reg == ST_OK && !is_pad && !sx.valid) begin
                err_next = ST_BAD_CHAR;
            end
            acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], sx_val};
            pos_next = POS_FOURTH;
        end else begin
            // fourth place closes the group
            if (err_reg == ST_OK) begin
                if (!is_pad && !sx.valid) begin
                    err_next = ST_BAD_CHAR;
                end else if (third_pad_reg && !is_pad) begin
                    err_next = ST_PAD_ORDER;
                end
            end
            if (CMP_W'(gc_reg) >= CMP_W'(max_groups_reg)) begin
                too_long_next = 1'b1;
            end
            if (gc_reg != {GROUP_COUNT_BITS{1'b1}}) begin
                gc_next = gc_reg + GROUP_COUNT_BITS'(1);
            end
            emit = (err_next == ST_OK) && !too_long_next;
            if (emit) begin
                bnd_nbytes_next = 2'd1 + {1'b0, !third_pad_reg} + {1'b0, !is_pad};
            end
            pos_next       = 2'd0;
            acc_next       = '0;
            third_pad_next = 1'b0;
        end

        if (in_last_reg) begin
            bnd_has_next = 1'b1;
            if (pos_next != 2'd0) begin
                bnd_status_next = ST_LENGTH;
            end else if (too_long_next) begin
                bnd_status_next = ST_TOO_LONG;
            end else begin
                bnd_status_next = err_next;
            end
            // message done, back to the reset state
            pos_next       = 2'd0;
            acc_next       = '0;
            third_pad_next = 1'b0;
            gc_next        = '0;
            err_next       = ST_OK;
            too_long_next  = 1'b0;
        end

        bnd_word_next     = word;
        n_res             = {1'b0, bnd_nbytes_next} + {2'b00, bnd_has_next};
        bnd_last_idx_next = 2'(n_res - 3'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            acc_reg       <= '0;
            third_pad_reg <= 1'b0;
            gc_reg        <= '0;
            err_reg       <= ST_OK;
            too_long_reg  <= 1'b0;
        end else if (load) begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
            gc_reg        <= gc_next;
            err_reg       <= err_next;
            too_long_reg  <= too_long_next;
        end
    end

    // ---------------------------------------------------------------- result bundle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_valid_reg <= 1'b0;
            bnd_idx_reg   <= 2'd0;
        end else if (load) begin
            bnd_valid_reg <= (n_res != 3'd0);
            bnd_idx_reg   <= 2'd0;
        end else if (bnd_done) begin
            bnd_valid_reg <= 1'b0;
        end else if (m_xfer) begin
            bnd_idx_reg   <= bnd_idx_reg + 2'd1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_last_idx_reg <= bnd_last_idx_next;
            bnd_nbytes_reg   <= bnd_nbytes_next;
            bnd_word_reg     <= bnd_word_next;
            bnd_status_reg   <= bnd_status_next;
        end
    end

    // ---------------------------------------------------------------- output
    // bytes come first, most significant first; the end result follows them
    assign out_is_byte = (bnd_idx_reg < bnd_nbytes_reg);

    always_comb begin
        case (bnd_idx_reg)
            2'd0:    out_byte = bnd_word_reg[23:16];
            2'd1:    out_byte = bnd_word_reg[15:8];
            2'd2:    out_byte = bnd_word_reg[7:0];
            default: out_byte = 8'd0;
        endcase
    end

    assign m_tvalid = bnd_valid_reg;
    assign m_tdata  = {5'd0,
                       out_is_byte ? ST_OK : bnd_status_reg,
                       out_is_byte ? out_byte : 8'd0};
    assign m_tuser  = {!out_is_byte, out_is_byte};
    assign m_tlast  = (bnd_idx_reg == bnd_last_idx_reg);

    // ---------------------------------------------------------------- checks
    // every result is either a byte or the end result
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tuser))
        else $error("result is neither a single byte nor a single end");

    // the end result always closes the run of its character
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("end result not last of run");

    // a byte result carries no status
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[10:8] == ST_OK))
        else $error("byte result with nonzero status");

    // output index never passes the bundle's last result
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bnd_valid_reg |-> (bnd_idx_reg <= bnd_last_idx_reg))
        else $error("bundle index beyond last result");

    // the final character leaves the message state cleared
    a_msg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_last_reg) |=> (pos_reg == 2'd0 && gc_reg == '0 &&
                                   err_reg == ST_OK && !too_long_reg))
        else $error("message state not cleared after final character");

endmodule
